/* rtl/mbe_pkg.sv */
package mbe_pkg;

    localparam int Q_W      = 32;
    localparam int Q_FRAC   = 28;
    localparam int ITER_W   = 16;
    localparam int POW_W    = 3;
    localparam int MAG_W    = 48;
    localparam int MAG_FRAC = 24;
    localparam int IDX_W    = 3;

    // internal value width, product magnitude width, multiplier half width
    localparam int VW = 63;
    localparam int MW = 62;
    localparam int HW = 31;

    localparam logic signed [VW-1:0] SAT_LIM = {1'b0, {(VW-1){1'b1}}};
    localparam logic [MAG_W-1:0]     MAG_MAX = '1;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_ITER   = 3'd0,
        REG_POWER      = 3'd1,
        REG_JULIA_MODE = 3'd2,
        REG_JULIA_RE   = 3'd3,
        REG_JULIA_IM   = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [ITER_W-1:0]       max_iterations;
        logic [POW_W-1:0]        power_exponent;
        logic                    julia_mode;
        logic signed [Q_W-1:0]   julia_re;
        logic signed [Q_W-1:0]   julia_im;
    } cfg_t;

    typedef struct packed {
        logic                  start;
        logic signed [VW-1:0]  a;
        logic signed [VW-1:0]  b;
    } mul_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [VW-1:0]  p;
    } mul_rsp_t;

    // saturating add or subtract, clamps to +-SAT_LIM
    function automatic logic signed [VW-1:0] sat_sum(
        input logic signed [VW-1:0] a,
        input logic signed [VW-1:0] b,
        input logic                 sub
    );
        logic signed [VW:0] s;
        logic signed [VW:0] lim;
        lim = {1'b0, SAT_LIM};
        if (sub)
            s = {a[VW-1], a} - {b[VW-1], b};
        else
            s = {a[VW-1], a} + {b[VW-1], b};
        if (s > lim)
            return SAT_LIM;
        else if (s < -lim)
            return -SAT_LIM;
        else
            return s[VW-1:0];
    endfunction

endpackage

/* rtl/mbe_if.sv */
interface mbe_point_if import mbe_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] point_re;
    logic signed [Q_W-1:0] point_im;

    modport source (output valid, output point_re, output point_im, input ready);
    modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

interface mbe_result_if import mbe_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ITER_W-1:0] iteration_count;
    logic              escaped;
    logic [MAG_W-1:0]  final_magnitude_sq;

    modport source (output valid, output iteration_count, output escaped,
                    output final_magnitude_sq, input ready);
    modport sink   (input valid, input iteration_count, input escaped,
                    input final_magnitude_sq, output ready);
endinterface

interface mbe_cfg_if import mbe_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [Q_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/mbe_mul.sv */
module mbe_mul import mbe_pkg::*; #(
    parameter int FRAC_BITS = 28
) (
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [MW-1:0]        ma_reg, ma_next;
    logic [MW-1:0]        mb_reg, mb_next;
    logic [2*HW-1:0]      prod_reg, prod_next;
    logic [1:0]           pair_reg, pair_next;
    logic [2*MW-1:0]      acc_reg, acc_next;
    logic signed [VW-1:0] res_reg, res_next;

    logic [VW-1:0]   abs_a;
    logic [VW-1:0]   abs_b;
    logic [HW-1:0]   a_half;
    logic [HW-1:0]   b_half;
    logic [2*MW-1:0] addend;
    logic [2*MW-1:0] shifted;
    logic [MW-1:0]   mag;

    assign abs_a  = req.a[VW-1] ? VW'(-req.a) : req.a;
    assign abs_b  = req.b[VW-1] ? VW'(-req.b) : req.b;
    assign a_half = cnt_reg[1] ? ma_reg[MW-1:HW] : ma_reg[HW-1:0];
    assign b_half = cnt_reg[0] ? mb_reg[MW-1:HW] : mb_reg[HW-1:0];

    always_comb
    begin
        case (pair_reg)
            2'd0:    addend = (2*MW)'(prod_reg);
            2'd3:    addend = (2*MW)'(prod_reg) << (2*HW);
            default: addend = (2*MW)'(prod_reg) << HW;
        endcase
    end

    assign shifted = acc_reg >> FRAC_BITS;
    assign mag     = (|shifted[2*MW-1:MW]) ? SAT_LIM[MW-1:0] : shifted[MW-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        prod_next = prod_reg;
        pair_next = pair_reg;
        acc_next  = acc_reg;
        res_next  = res_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                cnt_next  = 3'd0;
                neg_next  = req.a[VW-1] ^ req.b[VW-1];
                ma_next   = abs_a[MW-1:0];
                mb_next   = abs_b[MW-1:0];
                acc_next  = '0;
            end
        end
        else
        begin
            cnt_next = cnt_reg + 3'd1;
            // four partial products, each registered and accumulated in the following cycle
            if (!cnt_reg[2])
            begin
                prod_next = a_half * b_half;
                pair_next = cnt_reg[1:0];
            end
            if (cnt_reg != 3'd0 && cnt_reg <= 3'd4)
                acc_next = acc_reg + addend;
            if (cnt_reg == 3'd5)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        prod_reg <= prod_next;
        pair_reg <= pair_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = res_reg;

endmodule

/* rtl/mbe_core.sv */
module mbe_core import mbe_pkg::*; #(
    parameter int FRAC_BITS = 28,
    parameter int MAX_POWER = 5
) (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    mbe_point_if.sink    point,
    mbe_result_if.source result,
    output mul_req_t mul_req,
    input  mul_rsp_t mul_rsp
);

    localparam int SH_UP = (FRAC_BITS >= Q_FRAC) ? FRAC_BITS - Q_FRAC : 0;
    localparam int SH_DN = (FRAC_BITS < Q_FRAC) ? Q_FRAC - FRAC_BITS : 0;
    localparam int M_DN  = (FRAC_BITS >= MAG_FRAC) ? FRAC_BITS - MAG_FRAC : 0;
    localparam int M_UP  = (FRAC_BITS < MAG_FRAC) ? MAG_FRAC - FRAC_BITS : 0;
    localparam int SW    = $clog2(MAX_POWER);
    localparam logic [VW-1:0] BAIL = VW'(256) << FRAC_BITS;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_MRE  = 10'b0000000010,
        S_MIM  = 10'b0000000100,
        S_CHK  = 10'b0000001000,
        S_CA   = 10'b0000010000,
        S_CB   = 10'b0000100000,
        S_CC   = 10'b0001000000,
        S_CD   = 10'b0010000000,
        S_ADD  = 10'b0100000000,
        S_DONE = 10'b1000000000
    } state_t;

    function automatic logic signed [VW-1:0] to_int(input logic signed [Q_W-1:0] x);
        logic [Q_W-1:0]       mag;
        logic [Q_W-1:0]       mag_dn;
        logic signed [VW-1:0] up;
        up     = VW'(x) <<< SH_UP;
        mag    = x[Q_W-1] ? Q_W'(-x) : x;
        mag_dn = mag >> SH_DN;
        if (FRAC_BITS >= Q_FRAC)
            return up;
        else if (x[Q_W-1])
            return $signed(-VW'(mag_dn));
        else
            return $signed(VW'(mag_dn));
    endfunction

    function automatic logic [MAG_W-1:0] to_mag(input logic [VW-1:0] m);
        logic [VW-1:0] t;
        if (FRAC_BITS >= MAG_FRAC)
        begin
            t = m >> M_DN;
            return (t > VW'(MAG_MAX)) ? MAG_MAX : t[MAG_W-1:0];
        end
        else
        begin
            t = m << M_UP;
            return (m > (VW'(MAG_MAX) >> M_UP)) ? MAG_MAX : t[MAG_W-1:0];
        end
    endfunction

    state_t               state_reg, state_next;
    logic                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [VW-1:0] zre_reg, zre_next;
    logic signed [VW-1:0] zim_reg, zim_next;
    logic signed [VW-1:0] kre_reg, kre_next;
    logic signed [VW-1:0] kim_reg, kim_next;
    logic signed [VW-1:0] wre_reg, wre_next;
    logic signed [VW-1:0] wim_reg, wim_next;
    logic signed [VW-1:0] prod_reg, prod_next;
    logic signed [VW-1:0] tre_reg, tre_next;
    logic [VW-1:0]        mag_reg, mag_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic                 esc_reg, esc_next;
    logic [SW-1:0]        steps_reg, steps_next;
    logic [ITER_W-1:0]    out_count_reg, out_count_next;
    logic                 out_esc_reg, out_esc_next;
    logic [MAG_W-1:0]     out_mag_reg, out_mag_next;

    logic signed [VW-1:0] cre;
    logic signed [VW-1:0] cim;
    logic [SW-1:0]        steps_init;
    logic                 mul_start;

    assign cre = to_int(point.point_re);
    assign cim = to_int(point.point_im);

    // exponent clamped to 2..MAX_POWER, one complex product per step beyond the first
    always_comb
    begin
        if (32'(cfg.power_exponent) > MAX_POWER)
            steps_init = SW'(MAX_POWER - 1);
        else if (cfg.power_exponent < POW_W'(2))
            steps_init = SW'(1);
        else
            steps_init = SW'(cfg.power_exponent - POW_W'(1));
    end

    always_comb
    begin
        mul_req.start = mul_start;
        case (state_reg)
            S_MRE:   begin mul_req.a = zre_reg; mul_req.b = zre_reg; end
            S_MIM:   begin mul_req.a = zim_reg; mul_req.b = zim_reg; end
            S_CA:    begin mul_req.a = wre_reg; mul_req.b = zre_reg; end
            S_CB:    begin mul_req.a = wim_reg; mul_req.b = zim_reg; end
            S_CC:    begin mul_req.a = wre_reg; mul_req.b = zim_reg; end
            S_CD:    begin mul_req.a = wim_reg; mul_req.b = zre_reg; end
            default: begin mul_req.a = zre_reg; mul_req.b = zre_reg; end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        zre_next       = zre_reg;
        zim_next       = zim_reg;
        kre_next       = kre_reg;
        kim_next       = kim_reg;
        wre_next       = wre_reg;
        wim_next       = wim_reg;
        prod_next      = prod_reg;
        tre_next       = tre_reg;
        mag_next       = mag_reg;
        iter_next      = iter_reg;
        esc_next       = esc_reg;
        steps_next     = steps_reg;
        out_count_next = out_count_reg;
        out_esc_next   = out_esc_reg;
        out_mag_next   = out_mag_reg;
        mul_start      = 1'b0;

        if (result.ready)
            out_valid_next = 1'b0;

        if (state_reg inside {S_MRE, S_MIM, S_CA, S_CB, S_CC, S_CD})
        begin
            if (!pend_reg)
            begin
                mul_start = 1'b1;
                pend_next = 1'b1;
            end
            else if (mul_rsp.done)
                pend_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (point.valid)
                begin
                    if (cfg.julia_mode)
                    begin
                        zre_next = cre;
                        zim_next = cim;
                        kre_next = to_int(cfg.julia_re);
                        kim_next = to_int(cfg.julia_im);
                    end
                    else
                    begin
                        zre_next = '0;
                        zim_next = '0;
                        kre_next = cre;
                        kim_next = cim;
                    end
                    iter_next  = '0;
                    esc_next   = 1'b0;
                    state_next = S_MRE;
                end
            end
            S_MRE:
            begin
                if (mul_rsp.done)
                begin
                    prod_next  = mul_rsp.p;
                    state_next = S_MIM;
                end
            end
            S_MIM:
            begin
                if (mul_rsp.done)
                begin
                    mag_next   = $unsigned(prod_reg) + $unsigned(mul_rsp.p);
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (iter_reg < cfg.max_iterations)
                begin
                    if (mag_reg > BAIL)
                    begin
                        esc_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        wre_next   = zre_reg;
                        wim_next   = zim_reg;
                        steps_next = steps_init;
                        state_next = S_CA;
                    end
                end
                else
                    state_next = S_DONE;
            end
            S_CA:
            begin
                if (mul_rsp.done)
                begin
                    prod_next  = mul_rsp.p;
                    state_next = S_CB;
                end
            end
            S_CB:
            begin
                if (mul_rsp.done)
                begin
                    tre_next   = sat_sum(prod_reg, mul_rsp.p, 1'b1);
                    state_next = S_CC;
                end
            end
            S_CC:
            begin
                if (mul_rsp.done)
                begin
                    prod_next  = mul_rsp.p;
                    state_next = S_CD;
                end
            end
            S_CD:
            begin
                if (mul_rsp.done)
                begin
                    wim_next = sat_sum(prod_reg, mul_rsp.p, 1'b0);
                    wre_next = tre_reg;
                    if (steps_reg == SW'(1))
                        state_next = S_ADD;
                    else
                    begin
                        steps_next = steps_reg - SW'(1);
                        state_next = S_CA;
                    end
                end
            end
            S_ADD:
            begin
                zre_next   = sat_sum(wre_reg, kre_reg, 1'b0);
                zim_next   = sat_sum(wim_reg, kim_reg, 1'b0);
                iter_next  = iter_reg + ITER_W'(1);
                state_next = S_MRE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_count_next = iter_reg;
                    out_esc_next   = esc_reg;
                    out_mag_next   = to_mag(mag_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zre_reg       <= zre_next;
        zim_reg       <= zim_next;
        kre_reg       <= kre_next;
        kim_reg       <= kim_next;
        wre_reg       <= wre_next;
        wim_reg       <= wim_next;
        prod_reg      <= prod_next;
        tre_reg       <= tre_next;
        mag_reg       <= mag_next;
        iter_reg      <= iter_next;
        esc_reg       <= esc_next;
        steps_reg     <= steps_next;
        out_count_reg <= out_count_next;
        out_esc_reg   <= out_esc_next;
        out_mag_reg   <= out_mag_next;
    end

    assign point.ready               = (state_reg == S_IDLE);
    assign result.valid              = out_valid_reg;
    assign result.iteration_count    = out_count_reg;
    assign result.escaped            = out_esc_reg;
    assign result.final_magnitude_sq = out_mag_reg;

endmodule

/* rtl/multibrot_escape_time.sv */
// Escape-time engine for z = z^n + k (n = 2..MAX_POWER) in signed fixed point with
// FRAC_BITS fraction bits. Every real product goes through one shared 31x31 multiplier
// as four partial products. An iteration needs 4*(n-1)+2 products and passes through
// the states S_CHK and S_ADD as well; the time an item takes is set by the iteration
// count before escape or the limit. The point channel is held off while an item is in
// work; the result sits in an output register, so the next point is taken while a
// result waits. Config writes are always accepted but must only be made while the
// block is idle.
module multibrot_escape_time import mbe_pkg::*; #(
    parameter int FRAC_BITS = 28,
    parameter int MAX_POWER = 5
) (
    input  logic clk,
    input  logic rst_n,
    mbe_point_if.sink    point,
    mbe_result_if.source result,
    mbe_cfg_if.sink      cfg
);

    cfg_t     cfg_reg, cfg_next;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_MAX_ITER:   cfg_next.max_iterations = cfg.data[ITER_W-1:0];
                REG_POWER:      cfg_next.power_exponent = cfg.data[POW_W-1:0];
                REG_JULIA_MODE: cfg_next.julia_mode     = cfg.data[0];
                REG_JULIA_RE:   cfg_next.julia_re       = $signed(cfg.data);
                REG_JULIA_IM:   cfg_next.julia_im       = $signed(cfg.data);
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_iterations <= ITER_W'(256);
            cfg_reg.power_exponent <= POW_W'(2);
            cfg_reg.julia_mode     <= 1'b0;
            cfg_reg.julia_re       <= '0;
            cfg_reg.julia_im       <= '0;
        end
        else
            cfg_reg <= cfg_next;
    end

    assign cfg.ready = 1'b1;

    mbe_core #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_POWER (MAX_POWER)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .point   (point),
        .result  (result),
        .mul_req (mul_req),
        .mul_rsp (mul_rsp)
    );

    mbe_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

endmodule
